// File: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial chaining values and round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int FillW      = $clog2(BlockBytes);
  localparam int TotalW     = 61;
  localparam int QDepth     = 2;

  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // front-to-back request: one 512-bit block to compress
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_req_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: design/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream channels
// Valid/ready channels for input items and digest word items.
// ----------------------------------------------------------------------------
interface sha256_in_if import sha256_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha256_out_if import sha256_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher, top level
// Hashes a byte stream and returns the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// The front end takes one byte item a cycle and stalls only while it is
// handing a full or padded block to the two-entry block queue. The back end
// runs one round a cycle: each block is loaded, run through its rounds and
// added to the chaining value, for a sustained rate of about one byte item
// per cycle. A final item adds one or two padding blocks, then eight digest
// word items, one per cycle while out_ready is high.
module sha256_stream_hasher_top import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();
  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  blk_req_t fq_data, qb_data;

  assign in_ch.valid = in_valid;
  assign in_ch.data.data_byte = in_data_byte;
  assign in_ch.data.byte_present = in_byte_present;
  assign in_ch.data.end_of_message = in_end_of_message;
  assign in_ready = in_ch.ready;
  assign out_valid = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_digest_word = out_ch.data.digest_word;
  assign out_word_index = out_ch.data.word_index;
  assign out_last_word = out_ch.data.last_word;

  sha256_front u_front (
    .clk, .rst_n, .in_ch(in_ch),
    .req_valid(fq_valid), .req_ready(fq_ready), .req(fq_data)
  );

  sha256_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  sha256_back u_back (
    .clk, .rst_n,
    .req_valid(qb_valid), .req_ready(qb_ready), .req(qb_data),
    .out_ch(out_ch)
  );

endmodule

// File: design/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts byte items, packs blocks, appends padding and length.
// ----------------------------------------------------------------------------
module sha256_front import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sha256_in_if.sink  in_ch,
  output logic       req_valid,
  input  logic       req_ready,
  output blk_req_t   req
);

  typedef enum logic [2:0] {
    F_FILL = 3'b001,
    F_PAD1 = 3'b010,
    F_PAD2 = 3'b100
  } fstate_t;

  fstate_t              st_r, st_nxt;
  logic [511:0]         buf_r, buf_nxt;
  logic [FillW:0]       fill_r, fill_nxt;
  logic [TotalW-1:0]    total_r, total_nxt;
  logic                 req_valid_r, req_valid_nxt;
  blk_req_t             req_r, req_nxt;
  logic [63:0]          bits;
  logic [511:0]         padded;
  logic [511:0]         b;
  logic [FillW:0]       f;
  logic                 acc;

  assign in_ch.ready = (st_r == F_FILL) && !req_valid_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign req_valid = req_valid_r;
  assign req = req_r;
  assign bits = {total_r, 3'b000};

  always_comb begin
    padded = buf_r;
    for (int i = 0; i < BlockBytes; i++) begin
      if (i == int'(fill_r[FillW-1:0])) padded[511-8*i -: 8] = PadByte;
      else if (i > int'(fill_r[FillW-1:0])) padded[511-8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    st_nxt = st_r;
    buf_nxt = buf_r;
    fill_nxt = fill_r;
    total_nxt = total_r;
    req_valid_nxt = req_valid_r && !req_ready;
    req_nxt = req_r;
    b = buf_r;
    f = fill_r;
    case (st_r)
      F_FILL: begin
        if (acc) begin
          if (in_ch.data.byte_present) begin
            b[511-8*fill_r[FillW-1:0] -: 8] = in_ch.data.data_byte;
            f = fill_r + 1'b1;
            total_nxt = total_r + 1'b1;
          end
          buf_nxt = b;
          fill_nxt = f;
          if (f == (FillW+1)'(BlockBytes)) begin
            req_valid_nxt = 1'b1;
            req_nxt.block = b;
            req_nxt.final_blk = 1'b0;
            fill_nxt = '0;
          end
          if (in_ch.data.end_of_message) st_nxt = F_PAD1;
        end
      end
      F_PAD1: begin
        if (!req_valid_r) begin
          req_valid_nxt = 1'b1;
          if (fill_r > (FillW+1)'(BlockBytes - 9)) begin
            req_nxt.block = padded;
            req_nxt.final_blk = 1'b0;
            st_nxt = F_PAD2;
          end else begin
            req_nxt.block = {padded[511:64], bits};
            req_nxt.final_blk = 1'b1;
            st_nxt = F_FILL;
            fill_nxt = '0;
            total_nxt = '0;
          end
        end
      end
      F_PAD2: begin
        if (!req_valid_r) begin
          req_valid_nxt = 1'b1;
          req_nxt.block = {448'b0, bits};
          req_nxt.final_blk = 1'b1;
          st_nxt = F_FILL;
          fill_nxt = '0;
          total_nxt = '0;
        end
      end
      default: st_nxt = F_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_FILL;
      fill_r <= '0;
      total_r <= '0;
      req_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      total_r <= total_nxt;
      req_valid_r <= req_valid_nxt;
    end
    buf_r <= buf_nxt;
    req_r <= req_nxt;
  end

endmodule

// File: design/sha256_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Two-entry queue of block requests between front and back ends.
// ----------------------------------------------------------------------------
module sha256_queue import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  blk_req_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output blk_req_t rd_data
);

  blk_req_t             mem_r [QDepth];
  logic [$clog2(QDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QDepth):0]   cnt_r;
  logic                 wr, rd;

  assign wr_ready = cnt_r != ($clog2(QDepth)+1)'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(QDepth){1'b0}}, wr} - {{$clog2(QDepth){1'b0}}, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// File: design/sha256_back.sv
// ----------------------------------------------------------------------------
// SHA-256 back end
// Runs one compression round a cycle and emits digest words.
// ----------------------------------------------------------------------------
module sha256_back import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_ready,
  input  blk_req_t    req,
  sha256_out_if.source out_ch
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RUN  = 4'b0010,
    B_ADD  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t      st_r;
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];
  logic [5:0]   rnd_r;
  logic         fin_r;
  logic [2:0]   oi_r;
  logic [31:0]  t1, t2, s0, s1, wn;

  assign req_ready = (st_r == B_IDLE);
  assign out_ch.valid = (st_r == B_OUT);
  assign out_ch.data.digest_word = h_r[oi_r];
  assign out_ch.data.word_index = oi_r;
  assign out_ch.data.last_word = (oi_r == 3'd7);

  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = s1 + w_r[9] + s0 + w_r[0];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_r) + w_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      rnd_r <= '0;
      oi_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      case (st_r)
        B_IDLE: begin
          if (req_valid) begin
            for (int i = 0; i < 16; i++) w_r[i] <= req.block[511-32*i -: 32];
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            fin_r <= req.final_blk;
            rnd_r <= '0;
            st_r <= B_RUN;
          end
        end
        B_RUN: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          v_r[0] <= t1 + t2;
          v_r[1] <= v_r[0];
          v_r[2] <= v_r[1];
          v_r[3] <= v_r[2];
          v_r[4] <= v_r[3] + t1;
          v_r[5] <= v_r[4];
          v_r[6] <= v_r[5];
          v_r[7] <= v_r[6];
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) st_r <= B_ADD;
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          oi_r <= '0;
          st_r <= fin_r ? B_OUT : B_IDLE;
        end
        B_OUT: begin
          if (out_ch.ready) begin
            oi_r <= oi_r + 1'b1;
            if (oi_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
              st_r <= B_IDLE;
            end
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: design/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Checks digest word order and framing at the top-level ports.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word mismatch");

  a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words not contiguous");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word))
    else $error("stalled word changed");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid)
    else $error("word after last");

endmodule

bind sha256_stream_hasher_top sha256_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_digest_word,
  .out_word_index, .out_last_word
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams messages one byte at a time into the hasher and predicts each
// digest in software. Every digest word coming out is compared with the
// prediction. Both channels idle at random, and one long output stall fills
// the block queue so that the input has to wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import sha256_pkg::*; ();

  class digest_scoreboard;
    logic [31:0] chain[8];
    logic [7:0]  buf_bytes[64];
    int          fill;
    logic [60:0] byte_total;
    out_item_t   expected_words[$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = init_h(3'(i));
      fill = 0;
      byte_total = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {buf_bytes[4*i], buf_bytes[4*i+1], buf_bytes[4*i+2], buf_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(6'(i)) + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void note_input(in_item_t it);
      logic [63:0] bits;
      out_item_t   word;
      if (it.byte_present) begin
        buf_bytes[fill] = it.data_byte;
        fill++;
        byte_total++;
        if (fill == BlockBytes) begin
          compress();
          fill = 0;
        end
      end
      if (!it.end_of_message) return;
      bits = {byte_total, 3'b000};
      buf_bytes[fill] = PadByte;
      for (int i = fill + 1; i < BlockBytes; i++) buf_bytes[i] = '0;
      if (fill > BlockBytes - 9) begin
        compress();
        for (int i = 0; i < BlockBytes; i++) buf_bytes[i] = '0;
      end
      for (int i = 0; i < 8; i++) buf_bytes[BlockBytes - 1 - i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        word.digest_word = chain[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 7);
        expected_words.push_back(word);
      end
      restart();
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h", got.digest_word);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word expected %h got %h", want.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index expected %0d got %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word expected %0d got %0d", want.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_stream_hasher_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_data_byte      (in_ch.data.data_byte),
    .in_byte_present   (in_ch.data.byte_present),
    .in_end_of_message (in_ch.data.end_of_message),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_digest_word   (out_ch.data.digest_word),
    .out_word_index    (out_ch.data.word_index),
    .out_last_word     (out_ch.data.last_word)
  );

  digest_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off_req = 1'b0;

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
  end

  task automatic send_item(logic [7:0] b, logic present, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.data.data_byte = 8'($urandom);
      in_ch.data.byte_present = 1'($urandom);
      in_ch.data.end_of_message = 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data.data_byte = b;
    in_ch.data.byte_present = present;
    in_ch.data.end_of_message = eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(in_ch.data);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(1)) begin
        send_item(8'($urandom), 1'b1, 1'b1);
        return;
      end
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  int lens[] = '{0, 1, 55, 57, 63};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // empty message, empty items, byte on the final item, extreme bytes
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_item(8'haa, 1'b1, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 22 : 0;
      recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 22 : 0;
      if (phase == 0) begin
        // fill the block queue behind a long output stall
        hold_off_req = 1'b1;
        send_message(3);
        send_message(64);
        send_message(56);
      end else begin
        for (int m = 0; m < 2; m++) begin
          if ($urandom_range(5) == 0) send_message(lens[$urandom_range(lens.size() - 1)]);
          else send_message($urandom_range(12));
        end
      end
      drain();
    end

    repeat (200) @(negedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
